>>> rtl/core/cir_pkg.sv
package cir_pkg;

  // operand widths of the impulse datapath
  localparam int VEL_W   = 32;
  localparam int NRM_W   = 16;
  localparam int MASS_W  = 24;
  localparam int REST_W  = 17;
  localparam int NRM_FRAC = 14;

  // impulse magnitude p and the divider built around it
  localparam int P_W       = 37;
  localparam int DEN_W     = MASS_W + 1;
  localparam int NUM_W     = P_W + MASS_W;
  localparam int DIV_STEPS = P_W;

  // accept edge to result edge: 5 front stages, divider, 3 back stages
  localparam int LATENCY = DIV_STEPS + 9;

  localparam logic [REST_W:0] REST_ONE = (REST_W + 1)'(65536);

endpackage

>>> rtl/core/cir_div.sv
module cir_div import cir_pkg::*; (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [P_W-1:0]   quot,
  output logic             rem_nz
);

  // restoring divider, one quotient bit per stage; quotient known < 2^P_W
  logic [DEN_W-1:0] rem_r [DIV_STEPS+1];
  logic [P_W-1:0]   wrk_r [DIV_STEPS+1];
  logic [DEN_W-1:0] den_r [DIV_STEPS];

  always_ff @(posedge clk) begin
    rem_r[0] <= DEN_W'(num[NUM_W-1:P_W]);
    wrk_r[0] <= num[P_W-1:0];
    den_r[0] <= den;
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [DEN_W+1:0] trial;
    assign trial = {1'b0, rem_r[k], wrk_r[k][P_W-1]} - {2'b00, den_r[k]};

    always_ff @(posedge clk) begin
      if (!trial[DEN_W+1]) begin
        rem_r[k+1] <= trial[DEN_W-1:0];
        wrk_r[k+1] <= {wrk_r[k][P_W-2:0], 1'b1};
      end else begin
        rem_r[k+1] <= {rem_r[k][DEN_W-2:0], wrk_r[k][P_W-1]};
        wrk_r[k+1] <= {wrk_r[k][P_W-2:0], 1'b0};
      end
    end

    if (k + 1 < DIV_STEPS) begin : g_den
      always_ff @(posedge clk) begin
        den_r[k+1] <= den_r[k];
      end
    end
  end

  assign quot   = wrk_r[DIV_STEPS];
  assign rem_nz = |rem_r[DIV_STEPS];

endmodule

>>> rtl/core/collision_impulse_resolver_top.sv
// Collision impulse resolver with position correction.
//
// Input: one contact per beat, taken at a rising edge with start high and
// busy low. busy is high only while rst_n is low; otherwise the pipeline
// takes a contact every cycle.
// Output: out_valid strobes for one cycle with both new velocities and
// both position shifts; the receiver cannot stall, so nothing waits.
// Throughput: one contact per cycle. The latency is set by the bit-serial
// quotient pipeline (cir_div): one input register plus one stage per bit
// of the 37-bit impulse, with five front and three back stages around it
// (contact capture, difference products, dot sum, restitution scale, mass
// products; second-body split, normal products, add and saturate).
// Configuration: cfg_we writes restitution (Q1.16) at once; write only
// while no contact is in flight. Reset (rst_n low, synchronous) clears the
// valid bits and sets restitution to zero.
// Separating contacts and contacts between two immovable bodies pass the
// velocities unchanged with zero shifts.
module collision_impulse_resolver_top import cir_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [REST_W-1:0]        cfg_wdata,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [VEL_W-1:0]  in_first_velocity_x,
  input  logic signed [VEL_W-1:0]  in_first_velocity_y,
  input  logic signed [VEL_W-1:0]  in_first_velocity_z,
  input  logic signed [VEL_W-1:0]  in_second_velocity_x,
  input  logic signed [VEL_W-1:0]  in_second_velocity_y,
  input  logic signed [VEL_W-1:0]  in_second_velocity_z,
  input  logic signed [NRM_W-1:0]  in_normal_x,
  input  logic signed [NRM_W-1:0]  in_normal_y,
  input  logic signed [NRM_W-1:0]  in_normal_z,
  input  logic [MASS_W-1:0]        in_first_inverse_mass,
  input  logic [MASS_W-1:0]        in_second_inverse_mass,
  input  logic [MASS_W-1:0]        in_penetration,
  output logic                     out_valid,
  output logic signed [VEL_W-1:0]  out_new_first_velocity_x,
  output logic signed [VEL_W-1:0]  out_new_first_velocity_y,
  output logic signed [VEL_W-1:0]  out_new_first_velocity_z,
  output logic signed [VEL_W-1:0]  out_new_second_velocity_x,
  output logic signed [VEL_W-1:0]  out_new_second_velocity_y,
  output logic signed [VEL_W-1:0]  out_new_second_velocity_z,
  output logic signed [VEL_W-1:0]  out_first_shift_x,
  output logic signed [VEL_W-1:0]  out_first_shift_y,
  output logic signed [VEL_W-1:0]  out_first_shift_z,
  output logic signed [VEL_W-1:0]  out_second_shift_x,
  output logic signed [VEL_W-1:0]  out_second_shift_y,
  output logic signed [VEL_W-1:0]  out_second_shift_z
);

  localparam int PROD_W = VEL_W + 1 + NRM_W;   // (v2 - v1) * n
  localparam int DOT_W  = PROD_W + 2;          // sum of three
  localparam int VN_W   = DOT_W - 2 - NRM_FRAC;
  localparam int SP_W   = P_W + 1 + NRM_W;     // s * n
  localparam int QP_W   = MASS_W + 1 + NRM_W;  // q * n
  localparam int SUM_W  = SP_W - NRM_FRAC + 1;

  typedef struct packed {
    logic [2:0][VEL_W-1:0] v1;
    logic [2:0][VEL_W-1:0] v2;
    logic [2:0][NRM_W-1:0] n;
  } body_t;

  typedef struct packed {
    body_t       b;
    logic [P_W-1:0] p;
    logic        skip;
  } side_t;

  function automatic logic [VEL_W-1:0] sat32(input logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'({1'b0, {(VEL_W-1){1'b1}}});
    lo = -hi - SUM_W'(1);
    if (x > hi) return hi[VEL_W-1:0];
    if (x < lo) return lo[VEL_W-1:0];
    return x[VEL_W-1:0];
  endfunction

  // nothing is taken while reset holds the valid bits clear
  assign busy = !rst_n;

  logic [REST_W-1:0] rest_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rest_r <= '0;
    end else if (cfg_we) begin
      rest_r <= cfg_wdata;
    end
  end

  // valid bits: front stages 1..5, divider, back stages 6..7, output
  logic [5:1] vld_r;
  logic       vld6_r, vld7_r, out_valid_r;
  logic [DIV_STEPS:0] dvld_r;

  // stage 1: contact registered
  body_t b1_r;
  logic [MASS_W-1:0] m1_1_r, m2_1_r, pen1_r;

  always_ff @(posedge clk) begin
    b1_r.v1 <= {in_first_velocity_z, in_first_velocity_y, in_first_velocity_x};
    b1_r.v2 <= {in_second_velocity_z, in_second_velocity_y, in_second_velocity_x};
    b1_r.n  <= {in_normal_z, in_normal_y, in_normal_x};
    m1_1_r  <= in_first_inverse_mass;
    m2_1_r  <= in_second_inverse_mass;
    pen1_r  <= in_penetration;
  end

  // stage 2: per-axis (v2 - v1) * n
  logic signed [PROD_W-1:0] prod_nxt [3];
  logic signed [PROD_W-1:0] prod2_r [3];
  body_t b2_r;
  logic [MASS_W-1:0] m1_2_r, m2_2_r, pen2_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_nxt[i] = ($signed({b1_r.v2[i][VEL_W-1], b1_r.v2[i]})
                   - $signed({b1_r.v1[i][VEL_W-1], b1_r.v1[i]})) * $signed(b1_r.n[i]);
    end
  end

  always_ff @(posedge clk) begin
    prod2_r <= prod_nxt;
    b2_r    <= b1_r;
    m1_2_r  <= m1_1_r;
    m2_2_r  <= m2_1_r;
    pen2_r  <= pen1_r;
  end

  // stage 3: dot product, mass sum, skip decision
  logic signed [DOT_W-1:0] dot_nxt;
  logic signed [DOT_W-1:0] dot3_r;
  logic [DEN_W-1:0] sum3_r;
  logic skip3_r;
  body_t b3_r;
  logic [MASS_W-1:0] m1_3_r, pen3_r;

  assign dot_nxt = DOT_W'(prod2_r[0]) + DOT_W'(prod2_r[1]) + DOT_W'(prod2_r[2]);

  always_ff @(posedge clk) begin
    dot3_r  <= dot_nxt;
    sum3_r  <= {1'b0, m1_2_r} + {1'b0, m2_2_r};
    skip3_r <= dot_nxt[DOT_W-1] || (m1_2_r == '0 && m2_2_r == '0);
    b3_r    <= b2_r;
    m1_3_r  <= m1_2_r;
    pen3_r  <= pen2_r;
  end

  // stage 4: p = vn * (1 + e), Q1.16 scale dropped
  logic [VN_W-1:0] vn;
  logic [VN_W+REST_W:0] pe_full;
  logic [P_W-1:0] p4_r;
  logic [DEN_W-1:0] sum4_r;
  logic skip4_r;
  body_t b4_r;
  logic [MASS_W-1:0] m1_4_r, pen4_r;

  assign vn      = dot3_r[DOT_W-3:NRM_FRAC];  // dot is non-negative when used
  assign pe_full = vn * (REST_ONE + {1'b0, rest_r});

  always_ff @(posedge clk) begin
    p4_r    <= pe_full[P_W+15:16];
    sum4_r  <= sum3_r;
    skip4_r <= skip3_r;
    b4_r    <= b3_r;
    m1_4_r  <= m1_3_r;
    pen4_r  <= pen3_r;
  end

  // stage 5: dividends p * m1 and pen * m1
  logic [NUM_W-1:0] num_s5_r, num_q5_r;
  logic [DEN_W-1:0] den5_r;
  side_t side5_r;

  always_ff @(posedge clk) begin
    num_s5_r     <= p4_r * m1_4_r;
    num_q5_r     <= NUM_W'(pen4_r * m1_4_r);
    den5_r       <= sum4_r;
    side5_r.b    <= b4_r;
    side5_r.p    <= p4_r;
    side5_r.skip <= skip4_r;
  end

  // quotients; pen rides alongside the dividers in its own delay line
  logic [P_W-1:0] s1_quot, q1_quot;
  logic s1_nz, q1_nz;
  logic [MASS_W-1:0] pen_dly_r [DIV_STEPS+1];

  cir_div u_div_s (
    .clk    (clk),
    .num    (num_s5_r),
    .den    (den5_r),
    .quot   (s1_quot),
    .rem_nz (s1_nz)
  );

  cir_div u_div_q (
    .clk    (clk),
    .num    (num_q5_r),
    .den    (den5_r),
    .quot   (q1_quot),
    .rem_nz (q1_nz)
  );

  side_t side_r [DIV_STEPS+1];
  logic [MASS_W-1:0] pen5_r;

  always_ff @(posedge clk) begin
    pen5_r <= pen4_r;
  end

  always_ff @(posedge clk) begin
    side_r[0]    <= side5_r;
    pen_dly_r[0] <= pen5_r;
    for (int k = 0; k < DIV_STEPS; k++) begin
      side_r[k+1]    <= side_r[k];
      pen_dly_r[k+1] <= pen_dly_r[k];
    end
  end

  // stage 6: second-body share from the remainder; skip zeroes all shares
  side_t side_out;
  logic [P_W-1:0] s1_6_r, s2_6_r;
  logic [MASS_W-1:0] q1_6_r, q2_6_r;
  body_t b6_r;
  logic [MASS_W-1:0] q1_lo;

  assign side_out = side_r[DIV_STEPS];
  assign q1_lo    = q1_quot[MASS_W-1:0];

  always_ff @(posedge clk) begin
    b6_r <= side_out.b;
    if (side_out.skip) begin
      s1_6_r <= '0;
      s2_6_r <= '0;
      q1_6_r <= '0;
      q2_6_r <= '0;
    end else begin
      s1_6_r <= s1_quot;
      s2_6_r <= side_out.p - s1_quot - P_W'(s1_nz);
      q1_6_r <= q1_lo;
      q2_6_r <= pen_dly_r[DIV_STEPS] - q1_lo - MASS_W'(q1_nz);
    end
  end

  // stage 7: shares times normal
  logic signed [SP_W-1:0] ps1_7_r [3], ps2_7_r [3];
  logic signed [QP_W-1:0] pq1_7_r [3], pq2_7_r [3];
  body_t b7_r;
  logic skip7_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      ps1_7_r[i] <= $signed({1'b0, s1_6_r}) * $signed(b6_r.n[i]);
      ps2_7_r[i] <= $signed({1'b0, s2_6_r}) * $signed(b6_r.n[i]);
      pq1_7_r[i] <= $signed({1'b0, q1_6_r}) * $signed(b6_r.n[i]);
      pq2_7_r[i] <= $signed({1'b0, q2_6_r}) * $signed(b6_r.n[i]);
    end
    b7_r    <= b6_r;
    skip7_r <= (s1_6_r == '0) && (s2_6_r == '0) && (q1_6_r == '0) && (q2_6_r == '0);
  end

  // output stage: floor shift, add, saturate
  logic [2:0][VEL_W-1:0] nv1_nxt, nv2_nxt, sh1_nxt, sh2_nxt;
  logic [2:0][VEL_W-1:0] nv1_r, nv2_r, sh1_r, sh2_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nv1_nxt[i] = sat32(SUM_W'($signed(b7_r.v1[i])) + SUM_W'(ps1_7_r[i] >>> NRM_FRAC));
      nv2_nxt[i] = sat32(SUM_W'($signed(b7_r.v2[i])) - SUM_W'(ps2_7_r[i] >>> NRM_FRAC));
      sh1_nxt[i] = sat32(-SUM_W'(pq1_7_r[i] >>> NRM_FRAC));
      sh2_nxt[i] = sat32(SUM_W'(pq2_7_r[i] >>> NRM_FRAC));
    end
  end

  always_ff @(posedge clk) begin
    nv1_r <= nv1_nxt;
    nv2_r <= nv2_nxt;
    sh1_r <= sh1_nxt;
    sh2_r <= sh2_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      dvld_r      <= '0;
      vld6_r      <= 1'b0;
      vld7_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= {vld_r[4:1], start};
      dvld_r      <= {dvld_r[DIV_STEPS-1:0], vld_r[5]};
      vld6_r      <= dvld_r[DIV_STEPS];
      vld7_r      <= vld6_r;
      out_valid_r <= vld7_r;
    end
  end

  assign out_valid = out_valid_r;

  assign out_new_first_velocity_x  = nv1_r[0];
  assign out_new_first_velocity_y  = nv1_r[1];
  assign out_new_first_velocity_z  = nv1_r[2];
  assign out_new_second_velocity_x = nv2_r[0];
  assign out_new_second_velocity_y = nv2_r[1];
  assign out_new_second_velocity_z = nv2_r[2];
  assign out_first_shift_x         = sh1_r[0];
  assign out_first_shift_y         = sh1_r[1];
  assign out_first_shift_z         = sh1_r[2];
  assign out_second_shift_x        = sh2_r[0];
  assign out_second_shift_y        = sh2_r[1];
  assign out_second_shift_z        = sh2_r[2];

  // every accepted contact strobes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##LATENCY out_valid)
    else $error("result strobe missing after accept");

  // shares never exceed the impulse
  a_split: assert property (@(posedge clk) disable iff (!rst_n)
    vld6_r |-> ({1'b0, s1_6_r} + {1'b0, s2_6_r} <= {1'b0, $past(side_out.p)}))
    else $error("impulse split exceeds total");

  // zero shares give zero shifts and unchanged velocities
  a_pass: assert property (@(posedge clk) disable iff (!rst_n)
    (vld7_r && skip7_r) |=> (out_first_shift_x == '0 && out_second_shift_z == '0
                              && out_new_first_velocity_y == $past(b7_r.v1[1])))
    else $error("pass-through contact altered");

endmodule
